// ----- sv/cfi_pkg.sv -----
// cfi_pkg: widths, word types and helpers shared by the friction impulse block.
// No dependencies; imported by every other file in sv/ except cfi_queue.
package cfi_pkg;

    localparam int FS_W   = 24;          // friction_scale register
    localparam int VEL_W  = 32;
    localparam int N_W    = 18;          // normal components
    localparam int FR_W   = 21;          // friction coefficients
    localparam int IM_W   = 31;          // inverse masses
    localparam int RV_W   = 33;          // relative velocity
    localparam int D_W    = 36;          // normal speed, signed
    localparam int T_W    = 38;          // tangent, signed
    localparam int AB_W   = 37;          // tangent magnitude
    localparam int MU_W   = 29;          // scaled mean coefficient
    localparam int MS_W   = 32;          // inverse-mass sum
    localparam int PM_W   = 49;          // static limit and dynamic magnitude
    localparam int A_W    = 30;          // normalized tangent magnitude
    localparam int SQ_W   = 62;          // sum of squares
    localparam int R_W    = 31;          // square root
    localparam int RM_W   = 35;          // root remainder
    localparam int DR_W   = 47;          // unit vector divider remainder
    localparam int U_W    = 17;          // unit vector component magnitude
    localparam int SM_W   = 34;          // tangent speed magnitude
    localparam int JM_W   = 50;          // impulse magnitude quotient
    localparam int PR_W   = 67;          // final product
    localparam int PS_W   = 51;          // final product after the Q16 shift
    localparam int OUT_W  = 32;

    localparam int Q_SHIFT  = 16;
    localparam int NORM_TOP = 29;        // larger tangent magnitude lands in [2^29, 2^30)

    localparam logic [FS_W-1:0] FS_RESET = 24'd1966080;   // 30.0 in Q8.16

    // Context of one contact, produced by the front end.
    typedef struct packed {
        logic signed [RV_W-1:0] rvx;
        logic signed [RV_W-1:0] rvy;
        logic signed [T_W-1:0]  tx;
        logic signed [T_W-1:0]  ty;
        logic                   d_pos;
        logic                   d_zero;
        logic                   mus_zero;
        logic [PM_W-1:0]        thr_s;
        logic [PM_W-1:0]        km;
        logic [MS_W-1:0]        msum;
        logic                   nofric;
    } ctx_t;

    // Unit vector magnitudes and tangent speed sign, carried past the divider.
    typedef struct packed {
        logic [U_W-1:0] uxm;
        logic [U_W-1:0] uym;
        logic           sneg;
    } ucar_t;

    // One result word.
    typedef struct packed {
        logic signed [OUT_W-1:0] impulse_x;
        logic signed [OUT_W-1:0] impulse_y;
        logic                    applies;
        logic                    sliding;
    } res_t;

    // Sign and magnitude to a saturated 32 bit value.
    function automatic logic signed [OUT_W-1:0] sat32(input logic neg,
                                                      input logic [PS_W-1:0] m);
        logic signed [OUT_W-1:0] r;
        if (neg)
        begin
            if (m >= (PS_W'(1) << (OUT_W-1)))
                r = {1'b1, {(OUT_W-1){1'b0}}};
            else
                r = OUT_W'(0) - m[OUT_W-1:0];
        end
        else
        begin
            if (m > PS_W'({1'b0, {(OUT_W-1){1'b1}}}))
                r = {1'b0, {(OUT_W-1){1'b1}}};
            else
                r = m[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/contact_friction_impulse.sv -----
// contact_friction_impulse: top level; front end, contact queue, back end and
// result queue. Depends on cfi_pkg, cfi_front, cfi_queue and cfi_back.
//
// Coulomb friction impulse for one 2-D contact per word. Push a contact while
// full is low; pop a result while empty is low. The block sustains one contact
// per clock while results are popped: every stage is a register stage, so a new
// contact enters each cycle unless stalled. A contact passes 5 front stages, the
// contact queue and 107 back stages, the bit-per-stage square root taking 31,
// the unit vector divider 17 and the impulse divider 50. When pop stalls, the
// result queue fills and the back end and then the front end hold in turn; full
// rises only once both queues and pipelines are backed up. friction_scale
// (Q8.16, reset 30.0) is to be written through cfg_we/cfg_wdata only while no
// contact is in flight; the block itself does not enforce this. There is no
// clearing pass after reset; the block accepts at once.
module contact_friction_impulse
    import cfi_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [FS_W-1:0]           cfg_wdata,
    input  logic                      push,
    output logic                      full,
    input  logic signed [VEL_W-1:0]   vel_a_x,
    input  logic signed [VEL_W-1:0]   vel_a_y,
    input  logic signed [VEL_W-1:0]   vel_b_x,
    input  logic signed [VEL_W-1:0]   vel_b_y,
    input  logic signed [N_W-1:0]     normal_x,
    input  logic signed [N_W-1:0]     normal_y,
    input  logic [FR_W-1:0]           stat_fric_a,
    input  logic [FR_W-1:0]           stat_fric_b,
    input  logic [FR_W-1:0]           dyn_fric_a,
    input  logic [FR_W-1:0]           dyn_fric_b,
    input  logic [IM_W-1:0]           inv_mass_a,
    input  logic [IM_W-1:0]           inv_mass_b,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [OUT_W-1:0]   impulse_x,
    output logic signed [OUT_W-1:0]   impulse_y,
    output logic                      applies,
    output logic                      sliding
);
    // front end to contact queue
    logic q_push, q_full, q_pop, q_empty;
    ctx_t q_wdata, q_rdata;

    // back end to result queue
    logic o_push, o_full;
    res_t o_wdata, o_rdata;

    cfi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .full        (full),
        .vel_a_x     (vel_a_x),
        .vel_a_y     (vel_a_y),
        .vel_b_x     (vel_b_x),
        .vel_b_y     (vel_b_y),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .stat_fric_a (stat_fric_a),
        .stat_fric_b (stat_fric_b),
        .dyn_fric_a  (dyn_fric_a),
        .dyn_fric_b  (dyn_fric_b),
        .inv_mass_a  (inv_mass_a),
        .inv_mass_b  (inv_mass_b),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full)
    );

    // decouples the front end from back end stalls
    cfi_queue #(
        .W     ($bits(ctx_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    cfi_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .o_push  (o_push),
        .o_data  (o_wdata),
        .o_full  (o_full)
    );

    // result queue: the oldest result sits on the ports while empty is low
    cfi_queue #(
        .W     ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (o_push),
        .wr_data (o_wdata),
        .full    (o_full),
        .rd_en   (pop && !empty),
        .rd_data (o_rdata),
        .empty   (empty)
    );

    assign impulse_x = o_rdata.impulse_x;
    assign impulse_y = o_rdata.impulse_y;
    assign applies   = o_rdata.applies;
    assign sliding   = o_rdata.sliding;

endmodule

// ----- sv/cfi_queue.sv -----
// cfi_queue: small first-in first-out queue of W bit words in registers.
// Depends on nothing; used between front and back and at the result side.
module cfi_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- sv/cfi_front.sv -----
// cfi_front: five stage front end; relative velocity, normal speed, tangent,
// friction limits and the no-friction check. Depends on cfi_pkg.
module cfi_front
    import cfi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [FS_W-1:0]          cfg_wdata,
    input  logic                     push,
    output logic                     full,
    input  logic signed [VEL_W-1:0]  vel_a_x,
    input  logic signed [VEL_W-1:0]  vel_a_y,
    input  logic signed [VEL_W-1:0]  vel_b_x,
    input  logic signed [VEL_W-1:0]  vel_b_y,
    input  logic signed [N_W-1:0]    normal_x,
    input  logic signed [N_W-1:0]    normal_y,
    input  logic [FR_W-1:0]          stat_fric_a,
    input  logic [FR_W-1:0]          stat_fric_b,
    input  logic [FR_W-1:0]          dyn_fric_a,
    input  logic [FR_W-1:0]          dyn_fric_b,
    input  logic [IM_W-1:0]          inv_mass_a,
    input  logic [IM_W-1:0]          inv_mass_b,
    output logic                     q_push,
    output ctx_t                     q_data,
    input  logic                     q_full
);
    logic [FS_W-1:0] fs_reg;
    logic [4:0]      vld_reg;
    logic            en;

    assign en     = !vld_reg[4] || !q_full;
    assign full   = !en;
    assign q_push = vld_reg[4] && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fs_reg <= FS_RESET;
        else if (cfg_we)
            fs_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], push};
    end

    // stage 1: relative velocity, mass sum, scaled mean coefficients
    logic signed [RV_W-1:0] s1_rvx_reg, s1_rvy_reg, s1_rvx_next, s1_rvy_next;
    logic signed [N_W-1:0]  s1_nx_reg, s1_ny_reg;
    logic [MS_W-1:0]        s1_msum_reg, s1_msum_next;
    logic [MU_W-1:0]        s1_mus_reg, s1_mud_reg, s1_mus_next, s1_mud_next;
    logic [FS_W+FR_W:0]     ps_s, ps_d;

    always_comb
    begin
        s1_rvx_next  = $signed({vel_b_x[VEL_W-1], vel_b_x}) - $signed({vel_a_x[VEL_W-1], vel_a_x});
        s1_rvy_next  = $signed({vel_b_y[VEL_W-1], vel_b_y}) - $signed({vel_a_y[VEL_W-1], vel_a_y});
        s1_msum_next = {1'b0, inv_mass_a} + {1'b0, inv_mass_b};
        ps_s = (FS_W+FR_W+1)'(fs_reg) * (FS_W+FR_W+1)'({1'b0, stat_fric_a} + {1'b0, stat_fric_b});
        ps_d = (FS_W+FR_W+1)'(fs_reg) * (FS_W+FR_W+1)'({1'b0, dyn_fric_a} + {1'b0, dyn_fric_b});
        s1_mus_next = ps_s[FS_W+FR_W:Q_SHIFT+1];
        s1_mud_next = ps_d[FS_W+FR_W:Q_SHIFT+1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_rvx_reg  <= s1_rvx_next;
            s1_rvy_reg  <= s1_rvy_next;
            s1_nx_reg   <= normal_x;
            s1_ny_reg   <= normal_y;
            s1_msum_reg <= s1_msum_next;
            s1_mus_reg  <= s1_mus_next;
            s1_mud_reg  <= s1_mud_next;
        end
    end

    // stage 2: products of the dot product rv.n
    logic signed [RV_W+N_W-1:0] s2_px_reg, s2_py_reg;
    logic signed [RV_W-1:0]     s2_rvx_reg, s2_rvy_reg;
    logic signed [N_W-1:0]      s2_nx_reg, s2_ny_reg;
    logic [MS_W-1:0]            s2_msum_reg;
    logic [MU_W-1:0]            s2_mus_reg, s2_mud_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_px_reg   <= s1_rvx_reg * s1_nx_reg;
            s2_py_reg   <= s1_rvy_reg * s1_ny_reg;
            s2_rvx_reg  <= s1_rvx_reg;
            s2_rvy_reg  <= s1_rvy_reg;
            s2_nx_reg   <= s1_nx_reg;
            s2_ny_reg   <= s1_ny_reg;
            s2_msum_reg <= s1_msum_reg;
            s2_mus_reg  <= s1_mus_reg;
            s2_mud_reg  <= s1_mud_reg;
        end
    end

    // stage 3: normal speed d, truncated toward zero
    logic signed [RV_W+N_W:0] dot3;
    logic [RV_W+N_W:0]        dmag3;
    logic signed [D_W-1:0]    s3_d_next, s3_d_reg;
    logic signed [RV_W-1:0]   s3_rvx_reg, s3_rvy_reg;
    logic signed [N_W-1:0]    s3_nx_reg, s3_ny_reg;
    logic [MS_W-1:0]          s3_msum_reg;
    logic [MU_W-1:0]          s3_mus_reg, s3_mud_reg;

    always_comb
    begin
        dot3  = (RV_W+N_W+1)'(s2_px_reg) + (RV_W+N_W+1)'(s2_py_reg);
        dmag3 = dot3[RV_W+N_W] ? -dot3 : dot3;
        if (dot3[RV_W+N_W])
            s3_d_next = -$signed(dmag3[RV_W+N_W:Q_SHIFT]);
        else
            s3_d_next = $signed(dmag3[RV_W+N_W:Q_SHIFT]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_d_reg    <= s3_d_next;
            s3_rvx_reg  <= s2_rvx_reg;
            s3_rvy_reg  <= s2_rvy_reg;
            s3_nx_reg   <= s2_nx_reg;
            s3_ny_reg   <= s2_ny_reg;
            s3_msum_reg <= s2_msum_reg;
            s3_mus_reg  <= s2_mus_reg;
            s3_mud_reg  <= s2_mud_reg;
        end
    end

    // stage 4: d*n, and |d|*mu split in two partial products each
    logic [D_W-1:0]             dabs4;
    logic signed [D_W+N_W-1:0]  s4_dnx_reg, s4_dny_reg;
    logic [D_W+15:0]            s4_slo_reg, s4_dlo_reg;
    logic [D_W+MU_W-17:0]       s4_shi_reg, s4_dhi_reg;
    logic                       s4_dpos_reg, s4_dzero_reg, s4_muszero_reg;
    logic signed [RV_W-1:0]     s4_rvx_reg, s4_rvy_reg;
    logic [MS_W-1:0]            s4_msum_reg;

    assign dabs4 = s3_d_reg[D_W-1] ? -s3_d_reg : s3_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_dnx_reg     <= s3_d_reg * s3_nx_reg;
            s4_dny_reg     <= s3_d_reg * s3_ny_reg;
            s4_slo_reg     <= dabs4 * s3_mus_reg[15:0];
            s4_shi_reg     <= dabs4 * s3_mus_reg[MU_W-1:16];
            s4_dlo_reg     <= dabs4 * s3_mud_reg[15:0];
            s4_dhi_reg     <= dabs4 * s3_mud_reg[MU_W-1:16];
            s4_dpos_reg    <= !s3_d_reg[D_W-1] && (s3_d_reg != '0);
            s4_dzero_reg   <= (s3_d_reg == '0);
            s4_muszero_reg <= (s3_mus_reg == '0);
            s4_rvx_reg     <= s3_rvx_reg;
            s4_rvy_reg     <= s3_rvy_reg;
            s4_msum_reg    <= s3_msum_reg;
        end
    end

    // stage 5: tangent and the no-friction check
    logic [D_W+N_W-1:0]     dmx5, dmy5;
    logic signed [T_W-1:0]  offx5, offy5;
    ctx_t                   c5_next, c5_reg;

    always_comb
    begin
        dmx5 = s4_dnx_reg[D_W+N_W-1] ? -s4_dnx_reg : s4_dnx_reg;
        dmy5 = s4_dny_reg[D_W+N_W-1] ? -s4_dny_reg : s4_dny_reg;
        offx5 = $signed({1'b0, dmx5[T_W+Q_SHIFT-2:Q_SHIFT]});
        offy5 = $signed({1'b0, dmy5[T_W+Q_SHIFT-2:Q_SHIFT]});
        if (s4_dnx_reg[D_W+N_W-1])
            offx5 = -offx5;
        if (s4_dny_reg[D_W+N_W-1])
            offy5 = -offy5;
        c5_next.rvx      = s4_rvx_reg;
        c5_next.rvy      = s4_rvy_reg;
        c5_next.tx       = T_W'(s4_rvx_reg) - offx5;
        c5_next.ty       = T_W'(s4_rvy_reg) - offy5;
        c5_next.d_pos    = s4_dpos_reg;
        c5_next.d_zero   = s4_dzero_reg;
        c5_next.mus_zero = s4_muszero_reg;
        // (lo + hi*2^16) >> 16 == hi + (lo >> 16)
        c5_next.thr_s    = PM_W'(s4_shi_reg) + PM_W'(s4_slo_reg[D_W+15:Q_SHIFT]);
        c5_next.km       = PM_W'(s4_dhi_reg) + PM_W'(s4_dlo_reg[D_W+15:Q_SHIFT]);
        c5_next.msum     = s4_msum_reg;
        c5_next.nofric   = ((c5_next.tx == '0) && (c5_next.ty == '0)) || (s4_msum_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c5_reg <= c5_next;
    end

    assign q_data = c5_reg;

endmodule

// ----- sv/cfi_back.sv -----
// cfi_back: back end pipeline; tangent normalize, square root, unit vector
// dividers, tangent speed, impulse divider, static/dynamic choice. Uses cfi_pkg.
module cfi_back
    import cfi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  ctx_t q_data,
    output logic q_pop,
    output logic o_push,
    output res_t o_data,
    input  logic o_full
);
    localparam int RT_N   = R_W;          // one root bit a stage
    localparam int DV_N   = U_W;          // one unit vector bit a stage
    localparam int JM_N   = JM_W;         // one quotient bit a stage
    localparam int S_ABS  = 0;
    localparam int S_SH   = 1;
    localparam int S_SQ   = 2;
    localparam int S_SUM  = 3;
    localparam int S_RT0  = 4;
    localparam int S_DV0  = S_RT0 + RT_N;
    localparam int S_SP   = S_DV0 + DV_N;
    localparam int S_SS   = S_SP + 1;
    localparam int S_JM0  = S_SS + 1;
    localparam int S_CMP  = S_JM0 + JM_N;
    localparam int S_MUL  = S_CMP + 1;
    localparam int S_SAT  = S_MUL + 1;
    localparam int NST    = S_SAT + 1;
    localparam int PO_W   = $clog2(AB_W);

    logic           en;
    logic [NST-1:0] vld_reg;
    ctx_t           ctx_reg [NST];

    assign en     = !vld_reg[NST-1] || !o_full;
    assign q_pop  = en && q_valid;
    assign o_push = vld_reg[NST-1] && !o_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], q_valid};
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_ctx
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                    ctx_reg[k] <= q_data;
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                    ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    // magnitudes and position of the leading one of the larger
    logic [T_W-1:0]  tax, tay;
    logic [AB_W-1:0] ax0, ay0, mx0;
    logic [PO_W-1:0] pos0;
    logic [AB_W-1:0] abs_ax_reg, abs_ay_reg;
    logic [PO_W-1:0] abs_pos_reg;

    always_comb
    begin
        tax  = q_data.tx[T_W-1] ? -q_data.tx : q_data.tx;
        tay  = q_data.ty[T_W-1] ? -q_data.ty : q_data.ty;
        ax0  = tax[AB_W-1:0];
        ay0  = tay[AB_W-1:0];
        mx0  = (ax0 > ay0) ? ax0 : ay0;
        pos0 = PO_W'(NORM_TOP);
        for (int i = 0; i < AB_W; i++)
        begin
            if (mx0[i])
                pos0 = PO_W'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs_ax_reg  <= ax0;
            abs_ay_reg  <= ay0;
            abs_pos_reg <= pos0;
        end
    end

    // shift both by the same amount
    logic [A_W-1:0] sh_ax_next, sh_ay_next, sh_ax_reg, sh_ay_reg;

    always_comb
    begin
        if (abs_pos_reg >= PO_W'(NORM_TOP))
        begin
            sh_ax_next = A_W'(abs_ax_reg >> (abs_pos_reg - PO_W'(NORM_TOP)));
            sh_ay_next = A_W'(abs_ay_reg >> (abs_pos_reg - PO_W'(NORM_TOP)));
        end
        else
        begin
            sh_ax_next = A_W'(abs_ax_reg << (PO_W'(NORM_TOP) - abs_pos_reg));
            sh_ay_next = A_W'(abs_ay_reg << (PO_W'(NORM_TOP) - abs_pos_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_ax_reg <= sh_ax_next;
            sh_ay_reg <= sh_ay_next;
        end
    end

    // squares, then their sum
    logic [2*A_W-1:0] sq_x_reg, sq_y_reg;
    logic [A_W-1:0]   sq_ax_reg, sq_ay_reg, sum_ax_reg, sum_ay_reg;
    logic [SQ_W-1:0]  sum_q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg   <= sh_ax_reg * sh_ax_reg;
            sq_y_reg   <= sh_ay_reg * sh_ay_reg;
            sq_ax_reg  <= sh_ax_reg;
            sq_ay_reg  <= sh_ay_reg;
            sum_q_reg  <= SQ_W'(sq_x_reg) + SQ_W'(sq_y_reg);
            sum_ax_reg <= sq_ax_reg;
            sum_ay_reg <= sq_ay_reg;
        end
    end

    // square root, two radicand bits a stage
    logic [SQ_W-1:0] rt_q_in [RT_N];
    logic [RM_W-1:0] rt_rem_in [RT_N];
    logic [R_W-1:0]  rt_root_in [RT_N];
    logic [A_W-1:0]  rt_ax_in [RT_N], rt_ay_in [RT_N];
    logic [SQ_W-1:0] rt_q_reg [RT_N];
    logic [RM_W-1:0] rt_rem_reg [RT_N];
    logic [R_W-1:0]  rt_root_reg [RT_N];
    logic [A_W-1:0]  rt_ax_reg [RT_N], rt_ay_reg [RT_N];

    for (genvar i = 0; i < RT_N; i++)
    begin : g_rt
        logic [RM_W-1:0] rsh, tst;
        if (i == 0)
        begin : g_in0
            assign rt_q_in[i]    = sum_q_reg;
            assign rt_rem_in[i]  = '0;
            assign rt_root_in[i] = '0;
            assign rt_ax_in[i]   = sum_ax_reg;
            assign rt_ay_in[i]   = sum_ay_reg;
        end
        else
        begin : g_inn
            assign rt_q_in[i]    = rt_q_reg[i-1];
            assign rt_rem_in[i]  = rt_rem_reg[i-1];
            assign rt_root_in[i] = rt_root_reg[i-1];
            assign rt_ax_in[i]   = rt_ax_reg[i-1];
            assign rt_ay_in[i]   = rt_ay_reg[i-1];
        end
        assign rsh = {rt_rem_in[i][RM_W-3:0], rt_q_in[i][SQ_W-1:SQ_W-2]};
        assign tst = {2'b00, rt_root_in[i], 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_q_reg[i]  <= {rt_q_in[i][SQ_W-3:0], 2'b00};
                rt_ax_reg[i] <= rt_ax_in[i];
                rt_ay_reg[i] <= rt_ay_in[i];
                if (rsh >= tst)
                begin
                    rt_rem_reg[i]  <= rsh - tst;
                    rt_root_reg[i] <= {rt_root_in[i][R_W-2:0], 1'b1};
                end
                else
                begin
                    rt_rem_reg[i]  <= rsh;
                    rt_root_reg[i] <= {rt_root_in[i][R_W-2:0], 1'b0};
                end
            end
        end
    end

    // unit vector: (a << 16) / r, one quotient bit a stage, both components
    logic [DR_W-1:0] dv_rx_in [DV_N], dv_ry_in [DV_N];
    logic [U_W-1:0]  dv_qx_in [DV_N], dv_qy_in [DV_N];
    logic [R_W-1:0]  dv_r_in [DV_N];
    logic [DR_W-1:0] dv_rx_reg [DV_N], dv_ry_reg [DV_N];
    logic [U_W-1:0]  dv_qx_reg [DV_N], dv_qy_reg [DV_N];
    logic [R_W-1:0]  dv_r_reg [DV_N];

    for (genvar i = 0; i < DV_N; i++)
    begin : g_dv
        logic [DR_W-1:0] dsh;
        if (i == 0)
        begin : g_in0
            assign dv_rx_in[i] = DR_W'({rt_ax_reg[RT_N-1], {Q_SHIFT{1'b0}}});
            assign dv_ry_in[i] = DR_W'({rt_ay_reg[RT_N-1], {Q_SHIFT{1'b0}}});
            assign dv_qx_in[i] = '0;
            assign dv_qy_in[i] = '0;
            assign dv_r_in[i]  = rt_root_reg[RT_N-1];
        end
        else
        begin : g_inn
            assign dv_rx_in[i] = dv_rx_reg[i-1];
            assign dv_ry_in[i] = dv_ry_reg[i-1];
            assign dv_qx_in[i] = dv_qx_reg[i-1];
            assign dv_qy_in[i] = dv_qy_reg[i-1];
            assign dv_r_in[i]  = dv_r_reg[i-1];
        end
        assign dsh = DR_W'(dv_r_in[i]) << (DV_N - 1 - i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_r_reg[i] <= dv_r_in[i];
                if (dv_rx_in[i] >= dsh)
                begin
                    dv_rx_reg[i] <= dv_rx_in[i] - dsh;
                    dv_qx_reg[i] <= dv_qx_in[i] | (U_W'(1) << (DV_N - 1 - i));
                end
                else
                begin
                    dv_rx_reg[i] <= dv_rx_in[i];
                    dv_qx_reg[i] <= dv_qx_in[i];
                end
                if (dv_ry_in[i] >= dsh)
                begin
                    dv_ry_reg[i] <= dv_ry_in[i] - dsh;
                    dv_qy_reg[i] <= dv_qy_in[i] | (U_W'(1) << (DV_N - 1 - i));
                end
                else
                begin
                    dv_ry_reg[i] <= dv_ry_in[i];
                    dv_qy_reg[i] <= dv_qy_in[i];
                end
            end
        end
    end

    // tangent speed s = (rv.u) >> 16
    logic signed [U_W:0]        ux_s, uy_s;
    logic signed [RV_W+U_W:0]   sp_px_reg, sp_py_reg;
    logic [U_W-1:0]             sp_uxm_reg, sp_uym_reg;

    always_comb
    begin
        ux_s = $signed({1'b0, dv_qx_reg[DV_N-1]});
        uy_s = $signed({1'b0, dv_qy_reg[DV_N-1]});
        if (ctx_reg[S_SP-1].tx[T_W-1])
            ux_s = -ux_s;
        if (ctx_reg[S_SP-1].ty[T_W-1])
            uy_s = -uy_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_px_reg  <= ctx_reg[S_SP-1].rvx * ux_s;
            sp_py_reg  <= ctx_reg[S_SP-1].rvy * uy_s;
            sp_uxm_reg <= dv_qx_reg[DV_N-1];
            sp_uym_reg <= dv_qy_reg[DV_N-1];
        end
    end

    logic signed [RV_W+U_W+1:0] sdot;
    logic [RV_W+U_W+1:0]        smag;
    logic [SM_W-1:0]            ss_sm_reg;
    ucar_t                      ss_uc_reg;

    always_comb
    begin
        sdot = (RV_W+U_W+2)'(sp_px_reg) + (RV_W+U_W+2)'(sp_py_reg);
        smag = sdot[RV_W+U_W+1] ? -sdot : sdot;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_sm_reg      <= smag[SM_W+Q_SHIFT-1:Q_SHIFT];
            ss_uc_reg.uxm  <= sp_uxm_reg;
            ss_uc_reg.uym  <= sp_uym_reg;
            ss_uc_reg.sneg <= sdot[RV_W+U_W+1];
        end
    end

    // |jt| = (|s| << 16) / msum, restoring division, one bit a stage
    logic [JM_W-1:0] jm_dvd_in [JM_N], jm_q_in [JM_N];
    logic [MS_W-1:0] jm_rem_in [JM_N];
    ucar_t           jm_uc_in [JM_N];
    logic [JM_W-1:0] jm_dvd_reg [JM_N], jm_q_reg [JM_N];
    logic [MS_W-1:0] jm_rem_reg [JM_N];
    ucar_t           jm_uc_reg [JM_N];

    for (genvar i = 0; i < JM_N; i++)
    begin : g_jm
        logic [MS_W:0] trl;
        logic [MS_W:0] dsr;
        if (i == 0)
        begin : g_in0
            assign jm_dvd_in[i] = {ss_sm_reg, {Q_SHIFT{1'b0}}};
            assign jm_q_in[i]   = '0;
            assign jm_rem_in[i] = '0;
            assign jm_uc_in[i]  = ss_uc_reg;
        end
        else
        begin : g_inn
            assign jm_dvd_in[i] = jm_dvd_reg[i-1];
            assign jm_q_in[i]   = jm_q_reg[i-1];
            assign jm_rem_in[i] = jm_rem_reg[i-1];
            assign jm_uc_in[i]  = jm_uc_reg[i-1];
        end
        assign trl = {jm_rem_in[i], jm_dvd_in[i][JM_W-1]};
        assign dsr = {1'b0, ctx_reg[S_JM0+i-1].msum};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                jm_dvd_reg[i] <= {jm_dvd_in[i][JM_W-2:0], 1'b0};
                jm_uc_reg[i]  <= jm_uc_in[i];
                if (trl >= dsr)
                begin
                    jm_rem_reg[i] <= MS_W'(trl - dsr);
                    jm_q_reg[i]   <= {jm_q_in[i][JM_W-2:0], 1'b1};
                end
                else
                begin
                    jm_rem_reg[i] <= MS_W'(trl);
                    jm_q_reg[i]   <= {jm_q_in[i][JM_W-2:0], 1'b0};
                end
            end
        end
    end

    // static or dynamic choice
    ctx_t            cc;
    ucar_t           cu;
    logic [JM_W-1:0] cjm;
    logic            statik, negsrc;
    logic [JM_W-1:0] cm_mag_reg;
    logic            cm_negx_reg, cm_negy_reg, cm_stat_reg;
    logic [U_W-1:0]  cm_uxm_reg, cm_uym_reg;

    always_comb
    begin
        cc  = ctx_reg[S_CMP-1];
        cu  = jm_uc_reg[JM_N-1];
        cjm = jm_q_reg[JM_N-1];
        if (cc.d_pos)
            statik = (cjm <= JM_W'(cc.thr_s));
        else
            statik = (cjm == '0) && (cc.d_zero || cc.mus_zero);
        negsrc = statik ? cu.sneg : cc.d_pos;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cm_mag_reg  <= statik ? cjm : JM_W'(cc.km);
            cm_negx_reg <= negsrc ^ cc.tx[T_W-1];
            cm_negy_reg <= negsrc ^ cc.ty[T_W-1];
            cm_stat_reg <= statik;
            cm_uxm_reg  <= cu.uxm;
            cm_uym_reg  <= cu.uym;
        end
    end

    logic [PR_W-1:0] mu_px_reg, mu_py_reg;
    logic            mu_negx_reg, mu_negy_reg, mu_stat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mu_px_reg   <= PR_W'(cm_mag_reg) * PR_W'(cm_uxm_reg);
            mu_py_reg   <= PR_W'(cm_mag_reg) * PR_W'(cm_uym_reg);
            mu_negx_reg <= cm_negx_reg;
            mu_negy_reg <= cm_negy_reg;
            mu_stat_reg <= cm_stat_reg;
        end
    end

    // saturate and drop friction for a zero tangent or zero mass sum
    res_t sat_next, sat_reg;

    always_comb
    begin
        if (ctx_reg[S_SAT-1].nofric)
        begin
            sat_next.impulse_x = '0;
            sat_next.impulse_y = '0;
            sat_next.applies   = 1'b0;
            sat_next.sliding   = 1'b0;
        end
        else
        begin
            sat_next.impulse_x = sat32(mu_negx_reg, PS_W'(mu_px_reg >> Q_SHIFT));
            sat_next.impulse_y = sat32(mu_negy_reg, PS_W'(mu_py_reg >> Q_SHIFT));
            sat_next.applies   = 1'b1;
            sat_next.sliding   = !mu_stat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sat_reg <= sat_next;
    end

    assign o_data = sat_reg;

endmodule

// ----- sv/cfi_checker.sv -----
// cfi_checker: port level assertions on the result side, bound to the top level.
// Depends on cfi_pkg and contact_friction_impulse.
module cfi_checker
    import cfi_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    empty,
    input logic                    pop,
    input logic signed [OUT_W-1:0] impulse_x,
    input logic signed [OUT_W-1:0] impulse_y,
    input logic                    applies,
    input logic                    sliding
);
    // a waiting word is not dropped
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result word lost while stalled");

    // a waiting word does not change
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(impulse_x) && $stable(impulse_y)
                           && $stable(applies) && $stable(sliding))
        else $error("result word changed while stalled");

    // no friction means a zero impulse and the static flag
    a_no_fric: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !applies |-> impulse_x == '0 && impulse_y == '0 && !sliding)
        else $error("no-friction word carries an impulse");

    // sliding only where friction applies
    a_slide: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && sliding |-> applies)
        else $error("sliding without friction");

endmodule

bind contact_friction_impulse cfi_checker u_cfi_checker (.*);

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for contact_friction_impulse.
// Depends on cfi_pkg and the contact_friction_impulse RTL; a clocked driver feeds
// contacts from a queue, a clocked monitor checks results against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import cfi_pkg::*;

    localparam int LATENCY   = 130;     // extra wait after draining, covers the pipe with margin
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 440;     // plus 150 stall words and the directed set

    // One contact as pushed into the block.
    typedef struct {
        logic signed [VEL_W-1:0] vax, vay, vbx, vby;
        logic signed [N_W-1:0]   nx, ny;
        logic [FR_W-1:0]         sa, sb, da, db;
        logic [IM_W-1:0]         ma, mb;
    } contact_t;

    typedef struct {
        logic signed [OUT_W-1:0] ix, iy;
        logic                    app, sld;
    } impulse_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [FS_W-1:0] cfg_wdata = '0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    contact_t cur = '{default: '0};
    logic signed [OUT_W-1:0] impulse_x, impulse_y;
    logic applies, sliding;

    contact_t pending_contacts[$];
    impulse_t expected_impulses[$];
    logic [FS_W-1:0] scale_q = FS_RESET;   // predictor's copy of friction_scale
    int errors = 0;
    int cycles = 0;
    bit calm = 1'b0;          // no idling in the last part of the run
    bit hold_pop = 1'b0;      // long receiver stall request
    int send_gap = 0;
    int recv_gap = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    contact_friction_impulse u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .push(push), .full(full),
        .vel_a_x(cur.vax), .vel_a_y(cur.vay), .vel_b_x(cur.vbx), .vel_b_y(cur.vby),
        .normal_x(cur.nx), .normal_y(cur.ny),
        .stat_fric_a(cur.sa), .stat_fric_b(cur.sb),
        .dyn_fric_a(cur.da), .dyn_fric_b(cur.db),
        .inv_mass_a(cur.ma), .inv_mass_b(cur.mb),
        .empty(empty), .pop(pop),
        .impulse_x(impulse_x), .impulse_y(impulse_y),
        .applies(applies), .sliding(sliding)
    );

    // ---------------- predictor ----------------
    function automatic logic [63:0] magn(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Truncating shift on the magnitude (rounds toward zero).
    function automatic longint shr_tz(input longint v, input int s);
        logic [63:0] m;
        m = magn(v) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp32(input bit neg,
                                                        input logic [63:0] m);
        if (neg)
            return (m >= 64'h8000_0000) ? 32'sh8000_0000 : OUT_W'(-longint'(m));
        return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : OUT_W'(m);
    endfunction

    // Q16 product of magnitudes; 128-bit math makes the 64-bit overflow clamp explicit.
    function automatic logic signed [OUT_W-1:0] qmul(input bit neg,
                                                     input logic [63:0] a,
                                                     input logic [63:0] b);
        logic [127:0] p;
        logic [63:0] m;
        p = a * b;
        m = (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[79:16];
        return clamp32(neg, m);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] q);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > q) bt >>= 2;
        while (bt != 0)
        begin
            if (q >= res + bt)
            begin
                q -= res + bt;
                res = (res >> 1) + bt;
            end
            else
                res >>= 1;
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic impulse_t friction_impulse(input contact_t c);
        impulse_t o;
        longint rvx, rvy, d, tx, ty, ux, uy, s;
        logic [63:0] msum, mus, mud, ax, ay, m, r, jm, km;
        bit still, neg;
        o = '{default: '0};
        rvx = longint'(c.vbx) - longint'(c.vax);
        rvy = longint'(c.vby) - longint'(c.vay);
        msum = 64'(c.ma) + 64'(c.mb);
        mus = (64'(scale_q) * (64'(c.sa) + 64'(c.sb))) >> 17;
        mud = (64'(scale_q) * (64'(c.da) + 64'(c.db))) >> 17;
        d  = shr_tz(rvx * c.nx + rvy * c.ny, Q_SHIFT);
        tx = rvx - shr_tz(d * c.nx, Q_SHIFT);
        ty = rvy - shr_tz(d * c.ny, Q_SHIFT);
        if ((tx == 0 && ty == 0) || msum == 0)
            return o;
        ax = magn(tx);
        ay = magn(ty);
        m = ax > ay ? ax : ay;
        while (m >= (64'd1 << 30))
        begin
            ax >>= 1; ay >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            ax <<= 1; ay <<= 1; m <<= 1;
        end
        r = root64(ax * ax + ay * ay);
        ux = longint'((ax << 16) / r);
        uy = longint'((ay << 16) / r);
        if (tx < 0) ux = -ux;
        if (ty < 0) uy = -uy;
        s = shr_tz(rvx * ux + rvy * uy, Q_SHIFT);
        jm = (magn(s) << 16) / msum;
        if (d > 0)
            still = jm <= ((magn(d) * mus) >> 16);
        else
            still = (jm == 0) && (d == 0 || mus == 0);
        if (still)
        begin
            neg = s < 0;
            o.ix = qmul(neg != (ux < 0), jm, magn(ux));
            o.iy = qmul(neg != (uy < 0), jm, magn(uy));
        end
        else
        begin
            km = (magn(d) * mud) >> 16;
            neg = d > 0;
            o.ix = qmul(neg != (ux < 0), km, magn(ux));
            o.iy = qmul(neg != (uy < 0), km, magn(uy));
        end
        o.app = 1'b1;
        o.sld = !still;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp, cycles);
        errors++;
    endtask

    // ---------------- driver ----------------
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (push && !full)
                expected_impulses.push_back(friction_impulse(cur));
            if (push && full)
                ;   // hold the offered contact
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                push <= 1'b0;
            end
            else if (pending_contacts.size() != 0 && (calm || $urandom_range(0, 9) != 0))
            begin
                cur  <= pending_contacts.pop_front();
                push <= 1'b1;
            end
            else
            begin
                push <= 1'b0;
                if (!calm && pending_contacts.size() != 0)
                    send_gap <= $urandom_range(1, 18) - 1;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        impulse_t e;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_impulses.size() == 0)
                    report_mismatch("unexpected word", 1, 0);
                else
                begin
                    e = expected_impulses.pop_front();
                    if (impulse_x !== e.ix)
                        report_mismatch("impulse_x", longint'(impulse_x), longint'(e.ix));
                    if (impulse_y !== e.iy)
                        report_mismatch("impulse_y", longint'(impulse_y), longint'(e.iy));
                    if (applies !== e.app)
                        report_mismatch("applies", longint'(applies), longint'(e.app));
                    if (sliding !== e.sld)
                        report_mismatch("sliding", longint'(sliding), longint'(e.sld));
                end
            end
            if (hold_pop)
                pop <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                recv_gap <= $urandom_range(1, 18) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        if (cycles >= MAX_CYC)
        begin
            $display("[contact_friction_impulse] ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic contact_t rand_contact();
        contact_t c;
        int k;
        c.vax = $urandom; c.vay = $urandom; c.vbx = $urandom; c.vby = $urandom;
        k = $urandom_range(0, 3);
        // mostly modest speeds, sometimes full range
        if (k != 0)
        begin
            c.vax = c.vax >>> $urandom_range(4, 14);
            c.vay = c.vay >>> $urandom_range(4, 14);
            c.vbx = c.vbx >>> $urandom_range(4, 14);
            c.vby = c.vby >>> $urandom_range(4, 14);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            c.nx = N_W'($urandom); c.ny = N_W'($urandom);   // raw, possibly out of range
        end
        else
        begin
            c.nx = N_W'($signed($urandom_range(0, 131072)) - 65536);
            c.ny = N_W'($signed($urandom_range(0, 131072)) - 65536);
        end
        c.sa = FR_W'($urandom_range(0, 1048576)); c.sb = FR_W'($urandom_range(0, 1048576));
        c.da = FR_W'($urandom_range(0, 1048576)); c.db = FR_W'($urandom_range(0, 1048576));
        if ($urandom_range(0, 9) == 0) c.sa = FR_W'($urandom);   // all bits
        if ($urandom_range(0, 9) == 0) c.db = FR_W'($urandom);
        c.ma = IM_W'($urandom); c.mb = IM_W'($urandom);
        if (k == 1) c.ma = c.ma >> $urandom_range(8, 28);
        if (k == 2) c.mb = c.mb >> $urandom_range(8, 28);
        case ($urandom_range(0, 15))
            0: c.ma = 0;
            1: c.mb = 0;
            2: begin c.ma = 0; c.mb = 0; end
            3: begin c.vax = 0; c.vay = 0; c.sa = 0; c.da = 0; c.ma = 0; end
            4: begin c.nx = 0; c.ny = 65536; end
            default: ;
        endcase
        return c;
    endfunction

    task automatic add(input logic signed [31:0] vax, vay, vbx, vby,
                       input logic signed [17:0] nx, ny,
                       input logic [20:0] s, dd, input logic [30:0] m);
        contact_t c;
        c = '{vax, vay, vbx, vby, nx, ny, s, s, dd, dd, m, m};
        pending_contacts.push_back(c);
    endtask

    task automatic wait_drained();
        while (pending_contacts.size() != 0 || push || expected_impulses.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_scale(input logic [FS_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        scale_q = v;
    endtask

    initial
    begin
        logic [FS_W-1:0] scales[5];
        scales = '{24'd0, 24'd8388608, 24'd65536, 24'hFFFFFF, 24'd1966080};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero tangent, zero mass sum, static/dynamic, odd normals
        add(0, 0, 0, 0, 0, 65536, 65536, 65536, 65536);                 // zero tangent
        add(0, 0, 32'sh10000, 0, 0, 65536, 65536, 65536, 0);           // zero mass sum
        add(0, 0, 32'sh10000, 32'sh10000, 0, 65536, 1048576, 0, 65536); // static
        add(0, 0, 32'sh10000, 32'sh10000, 0, 65536, 0, 1048576, 65536); // sliding
        add(0, 0, 32'sh10000, -32'sh10000, 0, 65536, 0, 65536, 65536);  // d < 0
        add(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
            -65536, 65536, 1048576, 1048576, 1);
        add(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
            65536, -65536, 21'h1FFFFF, 21'h1FFFFF, 31'h7FFFFFFF);
        add(5, -7, -3, 11, 18'sh1FFFF, 18'sh20000, 3, 9, 1);          // odd normal
        add(0, 0, 32'sh7FFFFFFF, 1, 65536, 0, 0, 1048576, 1);
        add(32'sh123456, -32'sh654321, 32'sh7FFF, 32'sh80000000, 0, 0, 0, 0, 31'h7FFFFFFF);
        add(1, 1, 1, 1, 46341, 46341, 65536, 65536, 65536);           // equal velocities
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_scale(scales[ph]);
            // receiver stall while the sender keeps offering: fills the pipe
            if (ph == 1)
            begin
                hold_pop = 1'b1;
                for (int i = 0; i < 150; i++) pending_contacts.push_back(rand_contact());
                repeat (300) @(posedge clk);
                hold_pop = 1'b0;
            end
            if (ph == 4) calm = 1'b1;
            for (int i = 0; i < N_RANDOM / 5; i++) pending_contacts.push_back(rand_contact());
            wait_drained();   // sender pauses until every result has come
        end

        if (errors == 0)
            $display("[contact_friction_impulse] OK");
        else
            $display("[contact_friction_impulse] ERROR");
        $finish;
    end
endmodule
